[hdl/rci_pkg.sv]
// rci_pkg: shared types, constants and fixed-point helpers for the
// ray / infinite cylinder intersection pipeline.
// No dependencies; used by every module under hdl/.
`timescale 1ns / 1ps

package rci_pkg;

  // Register map of the configuration port
  localparam int REG_IDX_W = 3;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_X = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Y = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_CENTER_Z = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_X   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_Y   = 3'd4;
  localparam logic [REG_IDX_W-1:0] REG_AXIS_Z   = 3'd5;
  localparam logic [REG_IDX_W-1:0] REG_RADIUS   = 3'd6;

  // Fixed-point constants (Q16.16)
  localparam logic signed [17:0] AXIS_Z_RESET = 18'sd65536;
  localparam logic [30:0]        RADIUS_RESET = 31'd65536;
  localparam logic [31:0]        TWO_Q16      = 32'd131072;
  localparam logic signed [31:0] S32_MAX      = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] S32_MIN      = 32'sh8000_0000;

  // Pipeline depths of the sub-units
  localparam int PERP_LAT = 4;
  localparam int SQRT_LAT = 32;
  localparam int DIV_QW   = 31;
  localparam int DIV_LAT  = DIV_QW + 3;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] origin_z;
    logic signed [31:0] dir_x;
    logic signed [31:0] dir_y;
    logic signed [31:0] dir_z;
    logic        [30:0] max_len;
  } ray_t;

  typedef struct packed {
    logic signed [31:0] first_distance;
    logic signed [31:0] second_distance;
    logic               miss;
  } hit_t;

  // Round Q.32 fraction to Q.16, nearest with halves away from zero
  function automatic logic signed [48:0] round16(input logic signed [63:0] v);
    logic [63:0] mag;
    logic [48:0] r;
    mag = v[63] ? (64'd0 - v) : v;
    r = 49'((mag + 64'd32768) >> 16);
    round16 = v[63] ? (49'd0 - r) : r;
  endfunction

  // Saturate to 32-bit signed
  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      sat32 = S32_MAX;
    end else if (v < -64'sd2147483648) begin
      sat32 = S32_MIN;
    end else begin
      sat32 = v[31:0];
    end
  endfunction

endpackage

[hdl/rci_perp.sv]
// rci_perp: removes the axial part of a 3-vector, four register stages.
// Depends on rci_pkg (round16, sat32).
`timescale 1ns / 1ps

module rci_perp (
  input  logic               clk,
  input  logic signed [32:0] vec [3],
  input  logic signed [17:0] axis [3],
  output logic signed [31:0] perp [3]
);

  logic signed [50:0] prod [3];
  logic signed [32:0] v1 [3];
  logic signed [36:0] dot;
  logic signed [32:0] v2 [3];
  logic signed [54:0] corr [3];
  logic signed [32:0] v3 [3];

  // stage 1: component products of the axial dot
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      prod[i] <= vec[i] * axis[i];
      v1[i]   <= vec[i];
    end
  end

  // stage 2: exact sum, rounded to Q16.16
  always_ff @(posedge clk) begin
    dot <= 37'(rci_pkg::round16(64'(prod[0]) + 64'(prod[1]) + 64'(prod[2])));
    for (int i = 0; i < 3; i++) begin
      v2[i] <= v1[i];
    end
  end

  // stage 3: axial correction per component
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      corr[i] <= axis[i] * dot;
      v3[i]   <= v2[i];
    end
  end

  // stage 4: subtract rounded correction, saturate
  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      perp[i] <= rci_pkg::sat32(64'(v3[i]) - 64'(rci_pkg::round16(64'(corr[i]))));
    end
  end

endmodule

[hdl/rci_sqrt.sv]
// rci_sqrt: pipelined floor square root of a 64-bit value, one result bit
// per stage. Depends on rci_pkg (SQRT_LAT).
`timescale 1ns / 1ps

module rci_sqrt (
  input  logic        clk,
  input  logic [63:0] rad,
  output logic [31:0] root
);

  logic [63:0] sv [rci_pkg::SQRT_LAT];
  logic [63:0] sr [rci_pkg::SQRT_LAT];

  for (genvar k = 0; k < rci_pkg::SQRT_LAT; k++) begin : g_stage
    localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
    logic [63:0] cur_v;
    logic [63:0] cur_r;
    logic [63:0] trial;

    if (k == 0) begin : g_first
      assign cur_v = rad;
      assign cur_r = '0;
    end else begin : g_next
      assign cur_v = sv[k-1];
      assign cur_r = sr[k-1];
    end

    assign trial = cur_r + BIT;

    // one digit: subtract trial if it fits
    always_ff @(posedge clk) begin
      if (cur_v >= trial) begin
        sv[k] <= cur_v - trial;
        sr[k] <= (cur_r >> 1) + BIT;
      end else begin
        sv[k] <= cur_v;
        sr[k] <= cur_r >> 1;
      end
    end
  end

  assign root = sr[rci_pkg::SQRT_LAT-1][31:0];

endmodule

[hdl/rci_div.sv]
// rci_div: pipelined rounded signed divide (sign/magnitude numerator by a
// positive divisor) with 32-bit saturation. Depends on rci_pkg.
`timescale 1ns / 1ps

module rci_div (
  input  logic               clk,
  input  logic               neg,
  input  logic        [48:0] mag,
  input  logic        [30:0] den,
  output logic signed [31:0] quot
);

  localparam int QW = rci_pkg::DIV_QW;

  logic [49:0] n0;
  logic        neg0;
  logic [30:0] den0;
  logic [49:0] n1;
  logic        neg1;
  logic        ovf1;
  logic [30:0] den1;

  logic [49:0]   rem  [QW];
  logic [QW-1:0] quo  [QW];
  logic          sneg [QW];
  logic          sovf [QW];
  logic [30:0]   sden [QW];

  // bias for round to nearest
  always_ff @(posedge clk) begin
    n0   <= 50'(mag) + 50'(den[30:1]);
    neg0 <= neg;
    den0 <= den;
  end

  // quotient of 2^31 or more saturates
  always_ff @(posedge clk) begin
    ovf1 <= {12'd0, n0} >= {den0, 31'd0};
    n1   <= n0;
    neg1 <= neg0;
    den1 <= den0;
  end

  // restoring division, one quotient bit per stage, MSB first
  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int SH = QW - 1 - j;
    logic [49:0]   cur_rem;
    logic [QW-1:0] cur_quo;
    logic          cur_neg;
    logic          cur_ovf;
    logic [30:0]   cur_den;
    logic [61:0]   trial;

    if (j == 0) begin : g_first
      assign cur_rem = n1;
      assign cur_quo = '0;
      assign cur_neg = neg1;
      assign cur_ovf = ovf1;
      assign cur_den = den1;
    end else begin : g_next
      assign cur_rem = rem[j-1];
      assign cur_quo = quo[j-1];
      assign cur_neg = sneg[j-1];
      assign cur_ovf = sovf[j-1];
      assign cur_den = sden[j-1];
    end

    assign trial = 62'(cur_den) << SH;

    always_ff @(posedge clk) begin
      if ({12'd0, cur_rem} >= trial) begin
        rem[j] <= cur_rem - trial[49:0];
        quo[j] <= {cur_quo[QW-2:0], 1'b1};
      end else begin
        rem[j] <= cur_rem;
        quo[j] <= {cur_quo[QW-2:0], 1'b0};
      end
      sneg[j] <= cur_neg;
      sovf[j] <= cur_ovf;
      sden[j] <= cur_den;
    end
  end

  // apply sign and saturation
  always_ff @(posedge clk) begin
    if (sovf[QW-1]) begin
      quot <= sneg[QW-1] ? rci_pkg::S32_MIN : rci_pkg::S32_MAX;
    end else if (sneg[QW-1]) begin
      quot <= 32'd0 - {1'b0, quo[QW-1]};
    end else begin
      quot <= {1'b0, quo[QW-1]};
    end
  end

endmodule

[hdl/ray_cylinder_intersect.sv]
// Ray / infinite cylinder intersection, fully pipelined, Q16.16.
// Throughput: one ray per cycle.
// The depth is set by the 32-stage square root and 34-stage divider.
// busy is always low; results cannot be held off by the receiver.
// rst (synchronous) clears the valid pipe and loads the register defaults.
// Depends on rci_pkg, rci_perp, rci_sqrt, rci_div.
`timescale 1ns / 1ps

module ray_cylinder_intersect (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  rci_pkg::ray_t                  ray,
  output logic                           done,
  output rci_pkg::hit_t                  hit,
  input  logic                           wr_en,
  input  logic [rci_pkg::REG_IDX_W-1:0]  wr_index,
  input  logic [31:0]                    wr_data
);

  // cycle at which each stage's register holds an item
  localparam int L_PERP = 1 + rci_pkg::PERP_LAT;
  localparam int L_AHC  = L_PERP + 3;
  localparam int L_DISC = L_AHC + 2;
  localparam int L_Q    = L_DISC + rci_pkg::SQRT_LAT;
  localparam int L_NUM  = L_Q + 1;
  localparam int L_DIV  = L_NUM + rci_pkg::DIV_LAT;
  localparam int L_OUT  = L_DIV + 1;

  // configuration registers
  logic signed [31:0] center [3];
  logic signed [17:0] axis [3];
  logic        [30:0] radius;

  always_ff @(posedge clk) begin
    if (rst) begin
      center[0] <= '0;
      center[1] <= '0;
      center[2] <= '0;
      axis[0]   <= '0;
      axis[1]   <= '0;
      axis[2]   <= rci_pkg::AXIS_Z_RESET;
      radius    <= rci_pkg::RADIUS_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        rci_pkg::REG_CENTER_X: center[0] <= wr_data;
        rci_pkg::REG_CENTER_Y: center[1] <= wr_data;
        rci_pkg::REG_CENTER_Z: center[2] <= wr_data;
        rci_pkg::REG_AXIS_X:   axis[0]   <= wr_data[17:0];
        rci_pkg::REG_AXIS_Y:   axis[1]   <= wr_data[17:0];
        rci_pkg::REG_AXIS_Z:   axis[2]   <= wr_data[17:0];
        rci_pkg::REG_RADIUS:   radius    <= wr_data[30:0];
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // valid bits ride alongside the data
  logic [L_OUT-1:0] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[L_OUT-2:0], start & ~busy};
    end
  end

  // stage 0: offset origin, direction, miss value
  logic signed [32:0] lvec [3];
  logic signed [32:0] dvec [3];
  logic        [31:0] mv_sum;
  logic signed [31:0] mv_pipe [L_DIV];

  assign mv_sum = {1'b0, ray.max_len} + rci_pkg::TWO_Q16;

  always_ff @(posedge clk) begin
    lvec[0] <= {ray.origin_x[31], ray.origin_x} - {center[0][31], center[0]};
    lvec[1] <= {ray.origin_y[31], ray.origin_y} - {center[1][31], center[1]};
    lvec[2] <= {ray.origin_z[31], ray.origin_z} - {center[2][31], center[2]};
    dvec[0] <= {ray.dir_x[31], ray.dir_x};
    dvec[1] <= {ray.dir_y[31], ray.dir_y};
    dvec[2] <= {ray.dir_z[31], ray.dir_z};
    mv_pipe[0] <= mv_sum[31] ? rci_pkg::S32_MAX : mv_sum;
    for (int k = 1; k < L_DIV; k++) begin
      mv_pipe[k] <= mv_pipe[k-1];
    end
  end

  // perpendicular parts of direction and offset
  logic signed [31:0] dp [3];
  logic signed [31:0] lp [3];

  rci_perp u_perp_d (.clk(clk), .vec(dvec), .axis(axis), .perp(dp));
  rci_perp u_perp_l (.clk(clk), .vec(lvec), .axis(axis), .perp(lp));

  // quadratic terms: products, rounding, sums
  logic signed [63:0] pa [3];
  logic signed [63:0] ph [3];
  logic signed [63:0] pc [3];
  logic        [61:0] prr;
  logic signed [48:0] ra [3];
  logic signed [48:0] rh [3];
  logic signed [48:0] rc [3];
  logic signed [48:0] rrr;
  logic signed [31:0] qa;
  logic signed [31:0] qh;
  logic signed [31:0] qc;

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      pa[i] <= dp[i] * dp[i];
      ph[i] <= dp[i] * lp[i];
      pc[i] <= lp[i] * lp[i];
    end
    prr <= 62'(radius) * 62'(radius);
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      ra[i] <= rci_pkg::round16(pa[i]);
      rh[i] <= rci_pkg::round16(ph[i]);
      rc[i] <= rci_pkg::round16(pc[i]);
    end
    rrr <= rci_pkg::round16(64'(prr));
  end

  always_ff @(posedge clk) begin
    qa <= rci_pkg::sat32(64'(ra[0]) + 64'(ra[1]) + 64'(ra[2]));
    qh <= rci_pkg::sat32(64'(rh[0]) + 64'(rh[1]) + 64'(rh[2]));
    qc <= rci_pkg::sat32(64'(rc[0]) + 64'(rc[1]) + 64'(rc[2]) - 64'(rrr));
  end

  // discriminant quarter h*h - a*c
  logic signed [63:0] hh;
  logic signed [63:0] ac;
  logic signed [31:0] a8;
  logic signed [31:0] h8;
  logic signed [64:0] disc_full;
  logic        [63:0] disc;
  logic               miss_pipe [L_DIV-L_DISC+1];
  logic signed [31:0] h_pipe [L_Q-L_DISC+1];
  logic signed [31:0] a_pipe [L_Q-L_DISC+1];

  always_ff @(posedge clk) begin
    hh <= qh * qh;
    ac <= qa * qc;
    a8 <= qa;
    h8 <= qh;
  end

  assign disc_full = {hh[63], hh} - {ac[63], ac};

  always_ff @(posedge clk) begin
    disc         <= disc_full[63:0];
    miss_pipe[0] <= disc_full[64] | (a8 == 32'sd0);
    h_pipe[0]    <= h8;
    a_pipe[0]    <= a8;
    for (int k = 1; k < L_DIV - L_DISC + 1; k++) begin
      miss_pipe[k] <= miss_pipe[k-1];
    end
    for (int k = 1; k < L_Q - L_DISC + 1; k++) begin
      h_pipe[k] <= h_pipe[k-1];
      a_pipe[k] <= a_pipe[k-1];
    end
  end

  // square root
  logic [31:0] root;

  rci_sqrt u_sqrt (.clk(clk), .rad(disc), .root(root));

  // numerators (+sqrt and -sqrt), sign and magnitude
  logic signed [33:0] hx;
  logic signed [33:0] qx;
  logic signed [33:0] n1;
  logic signed [33:0] n2;
  logic        [32:0] m1;
  logic        [32:0] m2;
  logic               neg1;
  logic               neg2;
  logic        [48:0] mag1;
  logic        [48:0] mag2;
  logic        [30:0] den;

  assign hx = {{2{h_pipe[L_Q-L_DISC][31]}}, h_pipe[L_Q-L_DISC]};
  assign qx = {2'b00, root};
  assign n1 = qx - hx;
  assign n2 = 34'sd0 - hx - qx;
  assign m1 = n1[33] ? 33'(34'sd0 - n1) : n1[32:0];
  assign m2 = n2[33] ? 33'(34'sd0 - n2) : n2[32:0];

  always_ff @(posedge clk) begin
    neg1 <= n1[33];
    neg2 <= n2[33];
    mag1 <= {m1, 16'd0};
    mag2 <= {m2, 16'd0};
    den  <= a_pipe[L_Q-L_DISC][30:0];
  end

  // rounded divides by a
  logic signed [31:0] first_q;
  logic signed [31:0] second_q;

  rci_div u_div_first  (.clk(clk), .neg(neg1), .mag(mag1), .den(den), .quot(first_q));
  rci_div u_div_second (.clk(clk), .neg(neg2), .mag(mag2), .den(den), .quot(second_q));

  // result register: a miss reports max_len + 2 in both distances
  always_ff @(posedge clk) begin
    hit.miss <= miss_pipe[L_DIV-L_DISC];
    if (miss_pipe[L_DIV-L_DISC]) begin
      hit.first_distance  <= mv_pipe[L_DIV-1];
      hit.second_distance <= mv_pipe[L_DIV-1];
    end else begin
      hit.first_distance  <= first_q;
      hit.second_distance <= second_q;
    end
  end

  assign done = vld[L_OUT-1];

endmodule
